/* rtl/pes_pkg.sv */
// ----------------------------------------------------------------------------
// pes_pkg
// Shared types and constants of the path element splitter.
// ----------------------------------------------------------------------------
package pes_pkg;

	localparam int MAX_DEPTH_DEF = 32;
	localparam int MAX_LEN_DEF   = 4096;
	localparam int CHAR_W        = 16;
	localparam int STATUS_W      = 2;

	localparam logic [CHAR_W-1:0] CH_SQ_OPEN  = 16'h005B;
	localparam logic [CHAR_W-1:0] CH_CU_OPEN  = 16'h007B;
	localparam logic [CHAR_W-1:0] CH_SQ_CLOSE = 16'h005D;
	localparam logic [CHAR_W-1:0] CH_CU_CLOSE = 16'h007D;
	localparam logic [CHAR_W-1:0] CH_DOT      = 16'h002E;
	localparam logic [CHAR_W-1:0] CH_BSLASH   = 16'h005C;
	localparam logic [CHAR_W-1:0] CH_DQUOTE   = 16'h0022;
	localparam logic [CHAR_W-1:0] CH_SQUOTE   = 16'h0027;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_MISMATCH = 2'd1,
		ST_QUOTE    = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

endpackage

/* rtl/pes_parse.sv */
// ----------------------------------------------------------------------------
// pes_parse
// Parser state (quotes, escapes, bracket stack, positions, latched error)
// and the per-character element decision.
// ----------------------------------------------------------------------------
module pes_parse #(
	parameter int MAX_DEPTH = pes_pkg::MAX_DEPTH_DEF,
	parameter int MAX_LEN   = pes_pkg::MAX_LEN_DEF,
	localparam int PW = $clog2(MAX_LEN),
	localparam int LW = PW + 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  logic [pes_pkg::CHAR_W-1:0] char_code,
	input  logic                       last_char,
	output logic                       element_valid,
	output logic [PW-1:0]              element_start,
	output logic [LW-1:0]              element_length,
	output pes_pkg::status_t           status
);
	import pes_pkg::*;

	localparam int DW = $clog2(MAX_DEPTH + 1);

	logic [MAX_DEPTH-1:0] stack_q, stack_d;
	logic [DW-1:0]        depth_q, depth_d;
	logic                 in_str_q, in_str_d;
	logic                 sq_q, sq_d;
	logic                 esc_q, esc_d;
	logic [PW-1:0]        pos_q, pos_d, pos_inc;
	logic [PW-1:0]        anchor_q, anchor_d;
	status_t              err_q, err_d;

	logic [MAX_DEPTH:0]   push_v, pop_v;
	logic [LW-1:0]        gap;
	logic                 is_open, is_close, want, dot_split;

	assign pos_inc = (pos_q == PW'(MAX_LEN - 1)) ? '0 : pos_q + 1'b1;
	assign gap     = (pos_q >= anchor_q) ? LW'(pos_q) - LW'(anchor_q)
	                                     : LW'(pos_q) + LW'(MAX_LEN) - LW'(anchor_q);
	assign is_open  = (char_code == CH_SQ_OPEN) || (char_code == CH_CU_OPEN);
	assign is_close = (char_code == CH_SQ_CLOSE) || (char_code == CH_CU_CLOSE);
	assign want     = (char_code == CH_CU_CLOSE);
	assign push_v   = {stack_q, (char_code == CH_CU_OPEN)};
	assign pop_v    = {1'b0, stack_q};

	always_comb begin
		stack_d   = stack_q;
		depth_d   = depth_q;
		in_str_d  = in_str_q;
		sq_d      = sq_q;
		esc_d     = esc_q;
		anchor_d  = anchor_q;
		err_d     = err_q;
		dot_split = 1'b0;
		if (err_q == ST_OK) begin
			if (esc_q) begin
				esc_d = 1'b0;
			end else if (in_str_q) begin
				if (char_code == CH_BSLASH) begin
					esc_d = 1'b1;
				end else if ((!sq_q && char_code == CH_DQUOTE) ||
				             (sq_q && char_code == CH_SQUOTE)) begin
					in_str_d = 1'b0;
				end
			end else if (char_code == CH_DQUOTE || char_code == CH_SQUOTE) begin
				sq_d     = (char_code == CH_SQUOTE);
				in_str_d = 1'b1;
			end else if (is_open) begin
				if (depth_q == DW'(MAX_DEPTH)) begin
					err_d = ST_OVERFLOW;
				end else begin
					stack_d = push_v[MAX_DEPTH-1:0];
					depth_d = depth_q + 1'b1;
				end
			end else if (is_close) begin
				if (depth_q == '0 || stack_q[0] != want) begin
					err_d = ST_MISMATCH;
				end else begin
					stack_d = pop_v[MAX_DEPTH:1];
					depth_d = depth_q - 1'b1;
				end
			end else if (depth_q == '0 && char_code == CH_DOT) begin
				dot_split = 1'b1;
				anchor_d  = pos_inc;
			end
		end
	end

	// result fields
	always_comb begin
		status         = err_d;
		element_valid  = dot_split;
		element_start  = anchor_q;
		element_length = gap;
		if (last_char) begin
			if (status == ST_OK) begin
				if (depth_d != '0) begin
					status = ST_MISMATCH;
				end else if (in_str_d) begin
					status = ST_QUOTE;
				end
			end
			if (status == ST_OK && !dot_split) begin
				element_valid  = 1'b1;
				element_length = gap + 1'b1;
			end
			if (status != ST_OK) begin
				element_valid = 1'b0;
			end
		end
		if (!element_valid) begin
			element_start  = '0;
			element_length = '0;
		end
	end

	assign pos_d = last_char ? '0 : pos_inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q  <= '0;
			in_str_q <= 1'b0;
			sq_q     <= 1'b0;
			esc_q    <= 1'b0;
			pos_q    <= '0;
			anchor_q <= '0;
			err_q    <= ST_OK;
		end else if (step) begin
			if (last_char) begin
				depth_q  <= '0;
				in_str_q <= 1'b0;
				sq_q     <= 1'b0;
				esc_q    <= 1'b0;
				anchor_q <= '0;
				err_q    <= ST_OK;
			end else begin
				depth_q  <= depth_d;
				in_str_q <= in_str_d;
				sq_q     <= sq_d;
				esc_q    <= esc_d;
				anchor_q <= anchor_d;
				err_q    <= err_d;
			end
			pos_q <= pos_d;
		end
	end

	// bracket stack, top of stack in bit zero
	always_ff @(posedge clk) begin
		if (step) begin
			stack_q <= stack_d;
		end
	end

	a_depth_range: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DW'(MAX_DEPTH))
		else $error("bracket depth beyond limit");

	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		step && !last_char && err_q != ST_OK |=> err_q == $past(err_q))
		else $error("latched error changed before end of path");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && last_char |=> depth_q == '0 && err_q == ST_OK && pos_q == '0)
		else $error("state not cleared after last character");

endmodule

/* rtl/path_element_splitter_unit.sv */
// ----------------------------------------------------------------------------
// path_element_splitter_unit
// Splits a streamed path string into elements at top-level dots.
// ----------------------------------------------------------------------------
// One character enters per cycle while the output is not stalled and gives
// exactly one result. A character is held in an input register, runs
// combinationally through the parser and lands in the output register, so
// a new character is taken in every cycle while the result side keeps up.
// The parser state (quote and escape flags, bracket stack as a
// shift line, position, element anchor, latched error) updates once per
// character, and that update sets the rate. After the last character of a
// path all state but the bracket stack bits returns to its reset values.
module path_element_splitter_unit #(
	parameter int MAX_DEPTH = pes_pkg::MAX_DEPTH_DEF,
	parameter int MAX_LEN   = pes_pkg::MAX_LEN_DEF,
	localparam int PW  = $clog2(MAX_LEN),
	localparam int LW  = PW + 1,
	localparam int OW  = 1 + PW + LW + pes_pkg::STATUS_W,
	localparam int ODW = ((OW + 7) / 8) * 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [pes_pkg::CHAR_W-1:0] s_axis_tdata,  // char_code
	input  logic                       s_axis_tlast,  // last_char
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	output logic [ODW-1:0]             m_axis_tdata,  // element_valid, element_start,
	                                                  // element_length, status, zero fill
	output logic                       m_axis_tlast   // path_done
);
	import pes_pkg::*;

	logic                 vld_s1, vld_s2;
	logic [CHAR_W-1:0]    char_s1;
	logic                 last_s1, last_s2;
	logic                 ev_s2;
	logic [PW-1:0]        start_s2;
	logic [LW-1:0]        len_s2;
	status_t              status_s2;

	logic                 advance, step;
	logic                 ev_c;
	logic [PW-1:0]        start_c;
	logic [LW-1:0]        len_c;
	status_t              status_c;

	assign advance       = !vld_s2 || m_axis_tready;
	assign step          = vld_s1 && advance;
	assign s_axis_tready = !vld_s1 || advance;

	pes_parse #(
		.MAX_DEPTH (MAX_DEPTH),
		.MAX_LEN   (MAX_LEN)
	) u_parse (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (step),
		.char_code      (char_s1),
		.last_char      (last_s1),
		.element_valid  (ev_c),
		.element_start  (start_c),
		.element_length (len_c),
		.status         (status_c)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			char_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (advance) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			ev_s2     <= ev_c;
			start_s2  <= start_c;
			len_s2    <= len_c;
			status_s2 <= status_c;
			last_s2   <= last_s1;
		end
	end

	assign m_axis_tvalid = vld_s2;
	assign m_axis_tlast  = last_s2;
	assign m_axis_tdata  = ODW'({status_s2, len_s2, start_s2, ev_s2});

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !step |=> vld_s1 && $stable(char_s1) && $stable(last_s1))
		else $error("pending request lost in input register");

	a_elem_ok: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && ev_s2 |-> status_s2 == ST_OK)
		else $error("element given out with an error status");

	a_elem_zero: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && !ev_s2 |-> start_s2 == '0 && len_s2 == '0)
		else $error("start or length set without an element");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> len_s2 <= LW'(MAX_LEN))
		else $error("element length beyond limit");

endmodule
